[src/tkit_pkg.sv]
// ----------------------------------------------------------------------------
// tkit_pkg: shared types for the top-k index tracker
// transaction payloads and fixed field widths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkit_pkg;

  localparam int SCORE_W   = 32;
  localparam int BEST_ID_W = 32;
  localparam int KEEP_W    = 7;

  // one incoming scored item
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } item_t;

  // one reported slot
  typedef struct packed {
    logic [BEST_ID_W-1:0] best_id;
    logic                 valid_res;
    logic                 report_last;
  } result_t;

endpackage

[src/top_k_index_tracker.sv]
// ----------------------------------------------------------------------------
// top_k_index_tracker: keeps the stream positions of the best k scores
// scan: an item taken while slots are free is written straight into a free slot;
//   once the k slots are full an item is scanned (one slot read per cycle from the
//   score memory, then a compare and write-back of the weakest slot)
// report: an item marked last is followed by k result transactions, each read
//   through the single read port of the id memory
// reset: rst is synchronous; it empties the slot set, zeroes the position
//   counter and sets keep_count to 64; the slot memories are not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module top_k_index_tracker
  import tkit_pkg::*;
#(
  parameter int MAX_KEEP = 64,
  parameter int ID_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  // incoming scores
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  // reported slots
  output logic              res_valid,
  input  logic              res_stall,
  output result_t           res,
  // keep_count register
  input  logic              cfg_we,
  input  logic [KEEP_W-1:0] cfg_data
);

  // slot index and slot count widths
  localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RPT_RD,
    S_RPT_LD
  } state_t;

  state_t state;

  // slot memories, one read and one write port each
  logic signed [SCORE_W-1:0] mem_score [MAX_KEEP];
  logic        [ID_BITS-1:0] mem_id    [MAX_KEEP];
  logic signed [SCORE_W-1:0] rd_score;
  logic        [ID_BITS-1:0] rd_id;

  // control state
  logic [KEEP_W-1:0]  keep_count;
  logic [CNT_W-1:0]   fill_count;
  logic [ID_BITS-1:0] item_pos;
  logic [CNT_W-1:0]   issue_idx;   // next slot address to read in a scan
  logic [CNT_W-1:0]   rd_idx;      // slot whose data is on the read port
  logic               rd_vld;
  logic [CNT_W-1:0]   rpt_idx;     // slot being reported

  // the item under work
  logic signed [SCORE_W-1:0] cur_score;
  logic                      cur_last;
  logic [ID_BITS-1:0]        cur_id;

  // weakest slot found so far
  logic signed [SCORE_W-1:0] min_score;
  logic [CNT_W-1:0]          min_idx;

  // combinational control
  logic [CNT_W-1:0]          k_eff;
  logic                      item_acc;
  logic                      res_free;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic signed [SCORE_W-1:0] wr_score;
  logic [ID_BITS-1:0]        wr_id;
  logic                      rd_score_en;
  logic                      rd_id_en;
  logic [IDX_W-1:0]          rd_addr;
  logic                      issue;
  logic                      rpt_load;
  logic                      rpt_end;
  logic                      rpt_filled;
  logic                      take_new_min;

  // keep count clamped to 1..MAX_KEEP
  always_comb begin
    if (keep_count == '0) begin
      k_eff = CNT_W'(1);
    end else if (keep_count > KEEP_W'(MAX_KEEP)) begin
      k_eff = CNT_W'(MAX_KEEP);
    end else begin
      k_eff = CNT_W'(keep_count);
    end
  end

  // no transaction is taken while in reset or busy
  assign item_stall = rst || (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;

  // the output register can take a new result this cycle
  assign res_free = !res_valid || !res_stall;

  // scan issue: one slot address per cycle until k are out
  assign issue = (state == S_SCAN) && (issue_idx < k_eff);

  // minimum tracking: the first slot seeds it, later ones replace only on strictly less
  assign take_new_min = rd_vld && ((rd_idx == '0) || (rd_score < min_score));

  // report stage
  assign rpt_load   = (state == S_RPT_LD) && res_free;
  assign rpt_end    = (rpt_idx == k_eff - CNT_W'(1));
  assign rpt_filled = (rpt_idx < fill_count);

  // memory port control
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = fill_count[IDX_W-1:0];
    wr_score    = item.score;
    wr_id       = item_pos;
    rd_score_en = 1'b0;
    rd_id_en    = 1'b0;
    rd_addr     = issue_idx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        // direct fill while slots are still free
        wr_en = item_acc && (fill_count < k_eff);
      end
      S_SCAN: begin
        rd_score_en = issue;
      end
      S_DECIDE: begin
        // replace the weakest only on a strictly greater score
        wr_en    = (cur_score > min_score);
        wr_addr  = min_idx[IDX_W-1:0];
        wr_score = cur_score;
        wr_id    = cur_id;
      end
      S_RPT_RD: begin
        rd_id_en = 1'b1;
        rd_addr  = rpt_idx[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_score[wr_addr] <= wr_score;
      mem_id[wr_addr]    <= wr_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_score_en) begin
      rd_score <= mem_score[rd_addr];
    end
    if (rd_id_en) begin
      rd_id <= mem_id[rd_addr];
    end
  end

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      keep_count <= KEEP_W'(64);
      fill_count <= '0;
      item_pos   <= '0;
      issue_idx  <= '0;
      rd_idx     <= '0;
      rd_vld     <= 1'b0;
      rpt_idx    <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_count <= cfg_data;
      end

      // result transaction taken with nothing new behind it
      if (res_valid && !res_stall && !rpt_load) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_acc) begin
            cur_score <= item.score;
            cur_last  <= item.last;
            cur_id    <= item_pos;
            // saturating position counter
            if (item_pos != '1) begin
              item_pos <= item_pos + ID_BITS'(1);
            end
            rpt_idx <= '0;
            if (fill_count < k_eff) begin
              fill_count <= fill_count + CNT_W'(1);
              if (item.last) begin
                state <= S_RPT_RD;
              end
            end else begin
              issue_idx <= '0;
              rd_vld    <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // issue is already low once the final slot is on the read port
          rd_vld <= issue;
          rd_idx <= issue_idx;
          if (issue) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (take_new_min) begin
            min_score <= rd_score;
            min_idx   <= rd_idx;
          end
          if (rd_vld && (rd_idx == k_eff - CNT_W'(1))) begin
            state  <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (cur_last) begin
            state <= S_RPT_RD;
          end else begin
            state <= S_IDLE;
          end
        end

        S_RPT_RD: begin
          state <= S_RPT_LD;
        end

        S_RPT_LD: begin
          if (rpt_load) begin
            res_valid           <= 1'b1;
            // never-filled slots report their own index
            res.best_id         <= rpt_filled ? BEST_ID_W'(rd_id) : BEST_ID_W'(rpt_idx);
            res.valid_res       <= rpt_filled;
            res.report_last     <= rpt_end;
            if (rpt_end) begin
              // set finished: start afresh
              fill_count <= '0;
              item_pos   <= '0;
              state      <= S_IDLE;
            end else begin
              rpt_idx <= rpt_idx + CNT_W'(1);
              state   <= S_RPT_RD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks

  // the fill count never runs past the slot memory
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(MAX_KEEP))
    else $error("fill count beyond slot memory");

  // no slot is written while a scan is reading the slots
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !wr_en)
    else $error("slot write during scan");

  // a new result only ever comes out of the report stage
  a_res_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_RPT_LD))
    else $error("result raised outside report");

  // the final slot of a report empties the set
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (rpt_load && rpt_end) |=> (fill_count == '0 && item_pos == '0 && state == S_IDLE))
    else $error("set not cleared after report");

  // a scan reads no slot beyond the slot memory
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (issue_idx < CNT_W'(MAX_KEEP)))
    else $error("scan address out of range");

endmodule
